// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge.
`define ICR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define ICR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/icr_pkg.sv =====
package icr_pkg;

  typedef enum logic [1:0] {
    OUT_SKIP   = 2'd0,
    OUT_BOTH   = 2'd1,
    OUT_A_LOCK = 2'd2,
    OUT_B_LOCK = 2'd3
  } outcome_t;

  localparam int FRONT_STAGES = 5;
  localparam int DIV_STEPS    = 32;
  localparam int BACK_STAGES  = 4;
  localparam int ICR_LATENCY  = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

  localparam int NORM_FRAC = 14;
  localparam int VAL_FRAC  = 16;

  localparam logic [17:0]        ONE_Q16 = 18'd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [31:0]        inv_mass_a;
    logic [31:0]        inv_mass_b;
    logic [16:0]        restitution_a;
    logic [16:0]        restitution_b;
    logic [3:0]         body_flags;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [30:0]        depth;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic [31:0]        ima;
    logic [31:0]        imb;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    outcome_t           outcome;
    logic signed [31:0] mvax;
    logic signed [31:0] mvay;
    logic signed [31:0] mvbx;
    logic signed [31:0] mvby;
    logic signed [31:0] nvax;
    logic signed [31:0] nvay;
    logic signed [31:0] nvbx;
    logic signed [31:0] nvby;
  } side_t;

  typedef struct packed {
    logic [54:0] absn;
    logic [32:0] sum;
    logic        neg;
    side_t       side;
  } div_req_t;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic zero;
  } qflags_t;

  typedef struct packed {
    logic signed [31:0] move_a_x;
    logic signed [31:0] move_a_y;
    logic signed [31:0] move_b_x;
    logic signed [31:0] move_b_y;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    outcome_t           outcome;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'(S32_MAX)) r = S32_MAX;
    else if (x < 64'(S32_MIN)) r = S32_MIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/icr_front.sv =====
module icr_front import icr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  item_t    in_item,
  output logic     out_valid,
  output div_req_t out_req
);

  // stage 1: relative velocity, restitution, mass sum, case decode
  logic signed [32:0] relx1_nxt, rely1_nxt;
  logic [16:0]        e1_nxt;
  logic [32:0]        sum1_nxt;
  outcome_t           oc1_nxt;
  logic               v1_r;
  item_t              it1_r;
  logic signed [32:0] relx1_r, rely1_r;
  logic [16:0]        e1_r;
  logic [32:0]        sum1_r;
  outcome_t           oc1_r;

  always_comb begin
    relx1_nxt = 33'(in_item.vel_b_x) - 33'(in_item.vel_a_x);
    rely1_nxt = 33'(in_item.vel_b_y) - 33'(in_item.vel_a_y);
    e1_nxt = (in_item.restitution_a < in_item.restitution_b) ?
             in_item.restitution_a : in_item.restitution_b;
    sum1_nxt = 33'(in_item.inv_mass_a) + 33'(in_item.inv_mass_b);
    if (!(in_item.body_flags[2] || in_item.body_flags[3]) ||
        (in_item.body_flags[0] && in_item.body_flags[1])) begin
      oc1_nxt = OUT_SKIP;
    end else if (!in_item.body_flags[0] && !in_item.body_flags[1]) begin
      oc1_nxt = OUT_BOTH;
    end else if (in_item.body_flags[0]) begin
      oc1_nxt = OUT_A_LOCK;
    end else begin
      oc1_nxt = OUT_B_LOCK;
    end
  end

  // stage 2: products along the normal
  logic signed [31:0] fvx1, fvy1, dep1;
  logic signed [16:0] nnx1, nny1;
  logic signed [48:0] prx2_nxt, pry2_nxt, mnx2_nxt, mny2_nxt;
  logic signed [47:0] pvx2_nxt, pvy2_nxt, mpx2_nxt, mpy2_nxt;
  logic               v2_r;
  item_t              it2_r;
  logic [16:0]        e2_r;
  logic [32:0]        sum2_r;
  outcome_t           oc2_r;
  logic signed [31:0] fvx2_r, fvy2_r;
  logic signed [48:0] prx2_r, pry2_r, mnx2_r, mny2_r;
  logic signed [47:0] pvx2_r, pvy2_r, mpx2_r, mpy2_r;

  always_comb begin
    fvx1 = (oc1_r == OUT_A_LOCK) ? it1_r.vel_b_x : it1_r.vel_a_x;
    fvy1 = (oc1_r == OUT_A_LOCK) ? it1_r.vel_b_y : it1_r.vel_a_y;
    dep1 = $signed({1'b0, it1_r.depth});
    nnx1 = -17'(it1_r.normal_x);
    nny1 = -17'(it1_r.normal_y);
    prx2_nxt = 49'(relx1_r) * 49'(it1_r.normal_x);
    pry2_nxt = 49'(rely1_r) * 49'(it1_r.normal_y);
    pvx2_nxt = 48'(fvx1) * 48'(it1_r.normal_x);
    pvy2_nxt = 48'(fvy1) * 48'(it1_r.normal_y);
    mpx2_nxt = 48'(it1_r.normal_x) * 48'(dep1);
    mpy2_nxt = 48'(it1_r.normal_y) * 48'(dep1);
    mnx2_nxt = 49'(nnx1) * 49'(dep1);
    mny2_nxt = 49'(nny1) * 49'(dep1);
  end

  // stage 3: dot products and position corrections
  logic signed [35:0] dot3_nxt;
  logic signed [34:0] d3_nxt;
  logic signed [31:0] mvax3_nxt, mvay3_nxt, mvbx3_nxt, mvby3_nxt;
  logic               both2, a_moves2, b_moves2;
  logic               v3_r;
  item_t              it3_r;
  logic [16:0]        e3_r;
  logic [32:0]        sum3_r;
  outcome_t           oc3_r;
  logic signed [31:0] fvx3_r, fvy3_r;
  logic signed [35:0] dot3_r;
  logic signed [34:0] d3_r;
  logic signed [31:0] mvax3_r, mvay3_r, mvbx3_r, mvby3_r;

  always_comb begin
    both2    = (oc2_r == OUT_BOTH);
    a_moves2 = both2 || (oc2_r == OUT_B_LOCK);
    b_moves2 = both2 || (oc2_r == OUT_A_LOCK);
    dot3_nxt = 36'((50'(prx2_r) + 50'(pry2_r)) >>> NORM_FRAC);
    d3_nxt   = 35'((49'(pvx2_r) + 49'(pvy2_r)) >>> NORM_FRAC);
    mvax3_nxt = a_moves2 ? sat32(64'(both2 ? (mpx2_r >>> (NORM_FRAC + 1)) :
                                             (mpx2_r >>> NORM_FRAC))) : '0;
    mvay3_nxt = a_moves2 ? sat32(64'(both2 ? (mpy2_r >>> (NORM_FRAC + 1)) :
                                             (mpy2_r >>> NORM_FRAC))) : '0;
    mvbx3_nxt = b_moves2 ? sat32(64'(both2 ? (mnx2_r >>> (NORM_FRAC + 1)) :
                                             (mnx2_r >>> NORM_FRAC))) : '0;
    mvby3_nxt = b_moves2 ? sat32(64'(both2 ? (mny2_r >>> (NORM_FRAC + 1)) :
                                             (mny2_r >>> NORM_FRAC))) : '0;
  end

  // stage 4: impulse numerator and normal component of the free body
  logic signed [18:0] ef3;
  logic signed [54:0] np4_nxt;
  logic signed [50:0] qx4_nxt, qy4_nxt;
  logic               v4_r;
  item_t              it4_r;
  logic [32:0]        sum4_r;
  outcome_t           oc4_r;
  logic signed [31:0] fvx4_r, fvy4_r;
  logic signed [31:0] mvax4_r, mvay4_r, mvbx4_r, mvby4_r;
  logic signed [54:0] np4_r;
  logic signed [50:0] qx4_r, qy4_r;

  always_comb begin
    ef3     = $signed({1'b0, ONE_Q16 + 18'(e3_r)});
    np4_nxt = 55'(dot3_r) * 55'(ef3);
    qx4_nxt = 51'(it3_r.normal_x) * 51'(d3_r);
    qy4_nxt = 51'(it3_r.normal_y) * 51'(d3_r);
  end

  // stage 5: magnitude for the divider, velocities for the locked cases
  logic signed [31:0] frx4, fry4;
  div_req_t           req5_nxt;
  logic               v5_r;
  div_req_t           req5_r;

  always_comb begin
    frx4 = sat32(64'(fvx4_r) - 64'(qx4_r >>> NORM_FRAC));
    fry4 = sat32(64'(fvy4_r) - 64'(qy4_r >>> NORM_FRAC));
    req5_nxt.absn = np4_r[54] ? 55'(-np4_r) : np4_r;
    // numerator is the negated product: the quotient is negative when it is positive
    req5_nxt.neg  = !np4_r[54] && (np4_r != '0);
    req5_nxt.sum  = sum4_r;
    req5_nxt.side.vax  = it4_r.vel_a_x;
    req5_nxt.side.vay  = it4_r.vel_a_y;
    req5_nxt.side.vbx  = it4_r.vel_b_x;
    req5_nxt.side.vby  = it4_r.vel_b_y;
    req5_nxt.side.ima  = it4_r.inv_mass_a;
    req5_nxt.side.imb  = it4_r.inv_mass_b;
    req5_nxt.side.nx   = it4_r.normal_x;
    req5_nxt.side.ny   = it4_r.normal_y;
    req5_nxt.side.outcome = oc4_r;
    req5_nxt.side.mvax = mvax4_r;
    req5_nxt.side.mvay = mvay4_r;
    req5_nxt.side.mvbx = mvbx4_r;
    req5_nxt.side.mvby = mvby4_r;
    req5_nxt.side.nvax = (oc4_r == OUT_B_LOCK) ? frx4 : it4_r.vel_a_x;
    req5_nxt.side.nvay = (oc4_r == OUT_B_LOCK) ? fry4 : it4_r.vel_a_y;
    req5_nxt.side.nvbx = (oc4_r == OUT_A_LOCK) ? frx4 : it4_r.vel_b_x;
    req5_nxt.side.nvby = (oc4_r == OUT_A_LOCK) ? fry4 : it4_r.vel_b_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    it1_r   <= in_item;
    relx1_r <= relx1_nxt;
    rely1_r <= rely1_nxt;
    e1_r    <= e1_nxt;
    sum1_r  <= sum1_nxt;
    oc1_r   <= oc1_nxt;

    it2_r  <= it1_r;
    e2_r   <= e1_r;
    sum2_r <= sum1_r;
    oc2_r  <= oc1_r;
    fvx2_r <= fvx1;
    fvy2_r <= fvy1;
    prx2_r <= prx2_nxt;
    pry2_r <= pry2_nxt;
    pvx2_r <= pvx2_nxt;
    pvy2_r <= pvy2_nxt;
    mpx2_r <= mpx2_nxt;
    mpy2_r <= mpy2_nxt;
    mnx2_r <= mnx2_nxt;
    mny2_r <= mny2_nxt;

    it3_r   <= it2_r;
    e3_r    <= e2_r;
    sum3_r  <= sum2_r;
    oc3_r   <= oc2_r;
    fvx3_r  <= fvx2_r;
    fvy3_r  <= fvy2_r;
    dot3_r  <= dot3_nxt;
    d3_r    <= d3_nxt;
    mvax3_r <= mvax3_nxt;
    mvay3_r <= mvay3_nxt;
    mvbx3_r <= mvbx3_nxt;
    mvby3_r <= mvby3_nxt;

    it4_r   <= it3_r;
    sum4_r  <= sum3_r;
    oc4_r   <= oc3_r;
    fvx4_r  <= fvx3_r;
    fvy4_r  <= fvy3_r;
    mvax4_r <= mvax3_r;
    mvay4_r <= mvay3_r;
    mvbx4_r <= mvbx3_r;
    mvby4_r <= mvby3_r;
    np4_r   <= np4_nxt;
    qx4_r   <= qx4_nxt;
    qy4_r   <= qy4_nxt;

    req5_r <= req5_nxt;
  end

  assign out_valid = v5_r;
  assign out_req   = req5_r;

endmodule

// ===== rtl/icr_div.sv =====
module icr_div import icr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  div_req_t    in_req,
  output logic        out_valid,
  output logic [31:0] out_q,
  output qflags_t     out_flags,
  output side_t       out_side
);

  logic        v_r    [DIV_STEPS];
  logic [32:0] rem_r  [DIV_STEPS];
  logic [31:0] lo_r   [DIV_STEPS];
  logic [31:0] q_r    [DIV_STEPS];
  logic [32:0] sum_r  [DIV_STEPS];
  qflags_t     fl_r   [DIV_STEPS];
  side_t       side_r [DIV_STEPS];

  logic [32:0] rem0;
  qflags_t     fl0;

  // high part of the dividend seeds the remainder; quotient overflows 32 bits if it
  // already reaches the divisor
  always_comb begin
    rem0     = 33'(in_req.absn[54:32]);
    fl0.neg  = in_req.neg;
    fl0.ovf  = (rem0 >= in_req.sum);
    fl0.zero = (in_req.sum == '0);
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        v_in;
    logic [32:0] rem_in, sum_in, rem_nxt;
    logic [31:0] lo_in, q_in, lo_nxt, q_nxt;
    qflags_t     fl_in;
    side_t       side_in;
    logic [33:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = rem0;
      assign lo_in   = in_req.absn[31:0];
      assign q_in    = '0;
      assign sum_in  = in_req.sum;
      assign fl_in   = fl0;
      assign side_in = in_req.side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign lo_in   = lo_r[k-1];
      assign q_in    = q_r[k-1];
      assign sum_in  = sum_r[k-1];
      assign fl_in   = fl_r[k-1];
      assign side_in = side_r[k-1];
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
      t       = {rem_in, lo_in[31]};
      ge      = (t >= {1'b0, sum_in});
      rem_nxt = ge ? 33'(t - {1'b0, sum_in}) : t[32:0];
      lo_nxt  = {lo_in[30:0], 1'b0};
      q_nxt   = {q_in[30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      lo_r[k]   <= lo_nxt;
      q_r[k]    <= q_nxt;
      sum_r[k]  <= sum_in;
      fl_r[k]   <= fl_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[DIV_STEPS-1];
  assign out_q     = q_r[DIV_STEPS-1];
  assign out_flags = fl_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

// ===== rtl/icr_back.sv =====
module icr_back import icr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [31:0] in_q,
  input  qflags_t     in_flags,
  input  side_t       in_side,
  output logic        out_valid,
  output res_t        out_res
);

  // stage 1: signed, saturated impulse
  logic signed [31:0] j1_nxt;
  logic               v1_r;
  logic signed [31:0] j1_r;
  side_t              s1_r;

  always_comb begin
    if (in_flags.zero) begin
      j1_nxt = '0;
    end else if (in_flags.ovf) begin
      j1_nxt = in_flags.neg ? S32_MIN : S32_MAX;
    end else if (in_flags.neg) begin
      j1_nxt = (in_q > 32'h8000_0000) ? S32_MIN : $signed(-in_q);
    end else begin
      j1_nxt = in_q[31] ? S32_MAX : $signed(in_q);
    end
  end

  // stage 2: impulse scaled by each inverse mass
  logic signed [64:0] pa2_nxt, pb2_nxt;
  logic               v2_r;
  logic signed [64:0] pa2_r, pb2_r;
  side_t              s2_r;

  always_comb begin
    pa2_nxt = 65'(j1_r) * 65'($signed({1'b0, s1_r.ima}));
    pb2_nxt = 65'(j1_r) * 65'($signed({1'b0, s1_r.imb}));
  end

  // stage 3: project onto the normal
  logic signed [64:0] pax3_nxt, pay3_nxt, pbx3_nxt, pby3_nxt;
  logic               v3_r;
  logic signed [64:0] pax3_r, pay3_r, pbx3_r, pby3_r;
  side_t              s3_r;

  always_comb begin
    pax3_nxt = (pa2_r >>> VAL_FRAC) * 65'(s2_r.nx);
    pay3_nxt = (pa2_r >>> VAL_FRAC) * 65'(s2_r.ny);
    pbx3_nxt = (pb2_r >>> VAL_FRAC) * 65'(s2_r.nx);
    pby3_nxt = (pb2_r >>> VAL_FRAC) * 65'(s2_r.ny);
  end

  // stage 4: apply the impulse when both bodies are free; otherwise take the velocities from the front
  res_t res4_nxt;
  logic v4_r;
  res_t res4_r;

  always_comb begin
    res4_nxt.move_a_x = s3_r.mvax;
    res4_nxt.move_a_y = s3_r.mvay;
    res4_nxt.move_b_x = s3_r.mvbx;
    res4_nxt.move_b_y = s3_r.mvby;
    res4_nxt.outcome  = s3_r.outcome;
    if (s3_r.outcome == OUT_BOTH) begin
      res4_nxt.new_vel_a_x = sat32(64'(s3_r.vax) - 64'(pax3_r >>> NORM_FRAC));
      res4_nxt.new_vel_a_y = sat32(64'(s3_r.vay) - 64'(pay3_r >>> NORM_FRAC));
      res4_nxt.new_vel_b_x = sat32(64'(s3_r.vbx) + 64'(pbx3_r >>> NORM_FRAC));
      res4_nxt.new_vel_b_y = sat32(64'(s3_r.vby) + 64'(pby3_r >>> NORM_FRAC));
    end else begin
      res4_nxt.new_vel_a_x = s3_r.nvax;
      res4_nxt.new_vel_a_y = s3_r.nvay;
      res4_nxt.new_vel_b_x = s3_r.nvbx;
      res4_nxt.new_vel_b_y = s3_r.nvby;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    j1_r   <= j1_nxt;
    s1_r   <= in_side;
    pa2_r  <= pa2_nxt;
    pb2_r  <= pb2_nxt;
    s2_r   <= s1_r;
    pax3_r <= pax3_nxt;
    pay3_r <= pay3_nxt;
    pbx3_r <= pbx3_nxt;
    pby3_r <= pby3_nxt;
    s3_r   <= s2_r;
    res4_r <= res4_nxt;
  end

  assign out_valid = v4_r;
  assign out_res   = res4_r;

endmodule

// ===== rtl/impulse_collision_resolver_unit.sv =====
// Pipeline: 5 front stages, 32 divider steps and 4 back stages, all registered, lie
// between the accepting edge and out_valid rising.
// Throughput: one item per cycle; busy stays low, the 32-step divider is fully pipelined.
// Reset: synchronous, active low rst_n; clears every valid bit, no output strobes after.
// The receiver cannot stall; every item leaves in the order in which it entered.
`include "assert_macros.svh"

module impulse_collision_resolver_unit import icr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vel_a_x,
  input  logic signed [31:0] in_vel_a_y,
  input  logic signed [31:0] in_vel_b_x,
  input  logic signed [31:0] in_vel_b_y,
  input  logic [31:0]        in_inv_mass_a,
  input  logic [31:0]        in_inv_mass_b,
  input  logic [16:0]        in_restitution_a,
  input  logic [16:0]        in_restitution_b,
  input  logic [3:0]         in_body_flags,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic [30:0]        in_depth,
  output logic               out_valid,
  output logic signed [31:0] out_move_a_x,
  output logic signed [31:0] out_move_a_y,
  output logic signed [31:0] out_move_b_x,
  output logic signed [31:0] out_move_b_y,
  output logic signed [31:0] out_new_vel_a_x,
  output logic signed [31:0] out_new_vel_a_y,
  output logic signed [31:0] out_new_vel_b_x,
  output logic signed [31:0] out_new_vel_b_y,
  output logic [1:0]         out_outcome
);

  item_t       item;
  logic        fr_valid;
  div_req_t    fr_req;
  logic        dv_valid;
  logic [31:0] dv_q;
  qflags_t     dv_flags;
  side_t       dv_side;
  logic        bk_valid;
  res_t        bk_res;

  // every stage advances each cycle, so a new item is always welcome
  assign busy = 1'b0;

  always_comb begin
    item.vel_a_x       = in_vel_a_x;
    item.vel_a_y       = in_vel_a_y;
    item.vel_b_x       = in_vel_b_x;
    item.vel_b_y       = in_vel_b_y;
    item.inv_mass_a    = in_inv_mass_a;
    item.inv_mass_b    = in_inv_mass_b;
    item.restitution_a = in_restitution_a;
    item.restitution_b = in_restitution_b;
    item.body_flags    = in_body_flags;
    item.normal_x      = in_normal_x;
    item.normal_y      = in_normal_y;
    item.depth         = in_depth;
  end

  // front: case decode, dot products, position corrections, impulse numerator,
  // velocities for the one-locked cases
  icr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (item),
    .out_valid (fr_valid),
    .out_req   (fr_req)
  );

  // divider: numerator magnitude over the inverse-mass sum, one quotient bit per stage;
  // everything else about the item rides along beside it
  icr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_req    (fr_req),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_flags (dv_flags),
    .out_side  (dv_side)
  );

  // back: saturate the impulse, scale by inverse masses, update velocities
  icr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_q      (dv_q),
    .in_flags  (dv_flags),
    .in_side   (dv_side),
    .out_valid (bk_valid),
    .out_res   (bk_res)
  );

  assign out_valid       = bk_valid;
  assign out_move_a_x    = bk_res.move_a_x;
  assign out_move_a_y    = bk_res.move_a_y;
  assign out_move_b_x    = bk_res.move_b_x;
  assign out_move_b_y    = bk_res.move_b_y;
  assign out_new_vel_a_x = bk_res.new_vel_a_x;
  assign out_new_vel_a_y = bk_res.new_vel_a_y;
  assign out_new_vel_b_x = bk_res.new_vel_b_x;
  assign out_new_vel_b_y = bk_res.new_vel_b_y;
  assign out_outcome     = bk_res.outcome;

  `ICR_ASSERT_IMP(a_fixed_latency, out_valid, $past(start && !busy, ICR_LATENCY), "result without an item accepted 41 cycles earlier")
  `ICR_ASSERT_IMP(a_skip_no_move, out_valid && out_outcome == OUT_SKIP, out_move_a_x == 0 && out_move_a_y == 0 && out_move_b_x == 0 && out_move_b_y == 0, "skipped item moved a body")
  `ICR_ASSERT_IMP(a_a_locked_still, out_valid && out_outcome == OUT_A_LOCK, out_move_a_x == 0 && out_move_a_y == 0, "locked body A moved")
  `ICR_ASSERT(a_b_locked_still, !(out_valid && out_outcome == OUT_B_LOCK) || (out_move_b_x == 0 && out_move_b_y == 0), "locked body B moved")

endmodule
